>>> sv/ptoe_pkg.sv
// shared types and constants of the peer table with oldest-entry replacement
package ptoe_pkg;

    localparam int ID_W            = 32;
    localparam int TIME_W          = 32;
    localparam int TAG_W           = 8;
    localparam int SLOT_OUT_W      = 3;
    localparam int ENTRY_W         = ID_W + TIME_W;
    localparam int PEER_SLOTS_DEF  = 8;
    localparam int RESULT_LIMIT    = 8;
    localparam int CNT_W           = $clog2(RESULT_LIMIT);

    localparam logic MODE_BEACON   = 1'b0;
    localparam logic MODE_DISCOVER = 1'b1;
    localparam logic KIND_ENTRY    = 1'b0;
    localparam logic KIND_EMPTY    = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   peer_id;
        logic [TIME_W-1:0] now_ms;
        logic [TAG_W-1:0]  request_tag;
    } t_in_item;

    typedef struct packed {
        logic                  event_kind;
        logic [ID_W-1:0]       entry_id;
        logic [TIME_W-1:0]     entry_seen_ms;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [TAG_W-1:0]      tag_out;
        logic                  last;
    } t_out_item;

    // one slot presented to the compare unit
    typedef struct packed {
        logic              step;
        logic              first;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] seen;
    } t_scan_in;

endpackage

>>> sv/peer_table_oldest_eviction.sv
// top level of the peer table with oldest-entry replacement
//
// input channel: i_in_valid / o_in_stall carry one item (beacon or discover).
// output channel: o_out_valid / i_out_stall carry result items.
// config channel: i_cfg_valid / o_cfg_ready write own_id, always ready.
// a beacon from id zero or from own_id is dropped, no result, table unchanged.
// a beacon scans every slot through the one compare unit, one ram read per
// cycle, then writes the chosen slot and reports it once the output register
// is free; the input is ready again as that result is presented.
// a discover walks the slots in order, skipping a free slot, and gives a
// listed slot a ram read, then a result; at most 8 entries, last marked on
// the final one. an empty table gives one result with event_kind set, once
// the output register is free; the input is ready again as it is presented.
// o_in_stall is high while an item is in progress; a finished result waits in
// the output register and does not block the next accept, but the sequencer
// waits there if a new result meets a stalled, still-full output register.
// reset clears own_id, the per-slot occupied bits and the output valid flag;
// ram contents of an unoccupied slot are never used, so no clearing pass.
module peer_table_oldest_eviction #(
    parameter int PEER_SLOTS = ptoe_pkg::PEER_SLOTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  ptoe_pkg::t_in_item        i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ptoe_pkg::t_out_item       o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [ptoe_pkg::ID_W-1:0] i_cfg_data
);

    import ptoe_pkg::*;

    localparam int IDX_W = $clog2(PEER_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEER_SLOTS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(RESULT_LIMIT - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_WRITE = 6'b000100,
        ST_LRD   = 6'b001000,
        ST_LEMIT = 6'b010000,
        ST_EMPTY = 6'b100000
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [ID_W-1:0]     r_own_id;
    logic [PEER_SLOTS-1:0] r_occ, n_occ;      // slot occupied
    logic                r_issue_done, n_issue_done;
    logic                r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_out_vld, n_out_vld;

    // payload
    t_in_item            r_item, n_item;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    t_out_item           r_out, n_out;

    // ram and compare unit hookup
    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_q;
    logic [ID_W-1:0]     q_id;
    logic [TIME_W-1:0]   q_seen;
    t_scan_in            scan;
    logic [IDX_W-1:0]    chosen;

    logic                out_free;
    logic                in_acc;
    logic                more_above;
    logic                list_last;
    logic [PEER_SLOTS-1:0] occ_from_idx;

    assign q_id   = ram_q[ENTRY_W-1 -: ID_W];
    assign q_seen = ram_q[TIME_W-1:0];

    ptoe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PEER_SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (chosen),
        .i_wr_data ({r_item.peer_id, r_item.now_ms}),
        .i_rd_en   (ram_re),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_q)
    );

    // an unoccupied slot reads as id zero, time zero
    always_comb begin
        scan.step  = (r_state == ST_SCAN) && r_cmp_vld;
        scan.first = (r_cmp_idx == '0);
        scan.id    = r_occ[r_cmp_idx] ? q_id   : '0;
        scan.seen  = r_occ[r_cmp_idx] ? q_seen : '0;
    end

    ptoe_scan #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_scan (
        .i_clk  (i_clk),
        .i_scan (scan),
        .i_idx  (r_cmp_idx),
        .i_peer (r_item.peer_id),
        .o_slot (chosen)
    );

    assign out_free     = !r_out_vld || !i_out_stall;
    assign in_acc       = i_in_valid && (r_state == ST_IDLE);
    assign occ_from_idx = r_occ >> r_idx;
    assign more_above   = |(occ_from_idx >> 1);
    assign list_last    = (r_cnt == LAST_CNT) || !more_above;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_occ        = r_occ;
        n_issue_done = r_issue_done;
        n_cmp_vld    = r_cmp_vld;
        n_cnt        = r_cnt;
        n_out_vld    = r_out_vld;
        n_item       = r_item;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_item       = i_in_item;
                    n_idx        = '0;
                    n_cnt        = '0;
                    n_issue_done = 1'b0;
                    n_cmp_vld    = 1'b0;
                    if (i_in_item.mode == MODE_BEACON) begin
                        if (i_in_item.peer_id != '0 && i_in_item.peer_id != r_own_id) begin
                            n_state = ST_SCAN;
                        end
                    end else begin
                        n_state = (|r_occ) ? ST_LRD : ST_EMPTY;
                    end
                end
            end
            ST_SCAN: begin
                // read one slot per cycle, compare the one read the cycle before
                if (!r_issue_done) begin
                    ram_re    = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_cmp_vld && r_cmp_idx == LAST_IDX) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // rewriting the same entry while the output waits is harmless
                ram_we        = 1'b1;
                n_occ[chosen] = 1'b1;
                if (out_free) begin
                    n_out_vld           = 1'b1;
                    n_out.event_kind    = KIND_ENTRY;
                    n_out.entry_id      = r_item.peer_id;
                    n_out.entry_seen_ms = r_item.now_ms;
                    n_out.slot_index    = SLOT_OUT_W'(chosen);
                    n_out.tag_out       = '0;
                    n_out.last          = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            ST_LRD: begin
                // an occupied slot always lies at or above r_idx here
                if (r_occ[r_idx]) begin
                    ram_re  = 1'b1;
                    n_state = ST_LEMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_LEMIT: begin
                if (out_free) begin
                    n_out_vld           = 1'b1;
                    n_out.event_kind    = KIND_ENTRY;
                    n_out.entry_id      = q_id;
                    n_out.entry_seen_ms = q_seen;
                    n_out.slot_index    = SLOT_OUT_W'(r_idx);
                    n_out.tag_out       = r_item.request_tag;
                    n_out.last          = list_last;
                    if (list_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ST_LRD;
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    n_out_vld           = 1'b1;
                    n_out.event_kind    = KIND_EMPTY;
                    n_out.entry_id      = '0;
                    n_out.entry_seen_ms = '0;
                    n_out.slot_index    = '0;
                    n_out.tag_out       = r_item.request_tag;
                    n_out.last          = 1'b1;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_own_id     <= '0;
            r_occ        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_cnt        <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_occ        <= n_occ;
            r_issue_done <= n_issue_done;
            r_cmp_vld    <= n_cmp_vld;
            r_cnt        <= n_cnt;
            r_out_vld    <= n_out_vld;
            if (i_cfg_valid) begin
                r_own_id <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> sv/ptoe_ram.sv
// generic single-write, single-read ram with registered read data
module ptoe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/ptoe_scan.sv
// shared compare unit: tracks matching, first free and oldest slot over a scan
module ptoe_scan #(
    parameter int PEER_SLOTS = ptoe_pkg::PEER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  ptoe_pkg::t_scan_in            i_scan,
    input  logic [$clog2(PEER_SLOTS)-1:0] i_idx,
    input  logic [ptoe_pkg::ID_W-1:0]     i_peer,
    output logic [$clog2(PEER_SLOTS)-1:0] o_slot
);

    import ptoe_pkg::*;

    localparam int IDX_W = $clog2(PEER_SLOTS);

    logic              r_found;
    logic [IDX_W-1:0]  r_match_idx;
    logic              r_have_free;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_old_idx;
    logic [TIME_W-1:0] r_old_time;

    logic is_match;
    logic is_free;
    logic is_older;

    assign is_match = (i_scan.id == i_peer);
    assign is_free  = (i_scan.id == '0);
    assign is_older = (i_scan.seen < r_old_time);

    // first slot of a scan restarts every tracker
    always_ff @(posedge i_clk) begin
        if (i_scan.step) begin
            if (i_scan.first) begin
                r_found     <= is_match;
                r_match_idx <= i_idx;
                r_have_free <= is_free;
                r_free_idx  <= i_idx;
                r_old_idx   <= i_idx;
                r_old_time  <= i_scan.seen;
            end else begin
                if (is_match && !r_found) begin
                    r_found     <= 1'b1;
                    r_match_idx <= i_idx;
                end
                if (is_free && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= i_idx;
                end
                if (is_older) begin
                    r_old_idx  <= i_idx;
                    r_old_time <= i_scan.seen;
                end
            end
        end
    end

    assign o_slot = r_found     ? r_match_idx :
                    r_have_free ? r_free_idx  : r_old_idx;

endmodule

>>> sv/ptoe_checker.sv
// port-level checks of the peer table, bound to the top level
module ptoe_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input ptoe_pkg::t_in_item        i_in_item,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input ptoe_pkg::t_out_item       o_out_item
);

    import ptoe_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // an empty-table report carries zero fields and ends the item
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == KIND_EMPTY |->
            o_out_item.last && o_out_item.entry_id == '0 &&
            o_out_item.entry_seen_ms == '0 && o_out_item.slot_index == '0)
        else $error("malformed empty report");

    // a reported entry never holds the free marker
    a_entry_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.event_kind == KIND_ENTRY |->
            o_out_item.entry_id != '0)
        else $error("entry with zero id reported");

    // a discover always produces work, so the input stalls after it
    a_discover_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.mode == MODE_DISCOVER |=> o_in_stall)
        else $error("discover accepted without going busy");

endmodule

bind peer_table_oldest_eviction ptoe_checker u_ptoe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
